### sv/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg: shared types and constants of the answer-to-reset parser
// Word layouts, phase codes, byte kinds and status codes.
// ----------------------------------------------------------------------------
package sca_pkg;

    // parse phases, one-hot
    typedef enum logic [6:0] {
        PH_TS    = 7'b0000001,
        PH_T0    = 7'b0000010,
        PH_IFACE = 7'b0000100,
        PH_HIST  = 7'b0001000,
        PH_TCK   = 7'b0010000,
        PH_DONE  = 7'b0100000,
        PH_ERR   = 7'b1000000
    } phase_t;

    // byte classification codes
    localparam logic [3:0] KIND_TS   = 4'd0;
    localparam logic [3:0] KIND_T0   = 4'd1;
    localparam logic [3:0] KIND_TA   = 4'd2;
    localparam logic [3:0] KIND_TD   = 4'd5;
    localparam logic [3:0] KIND_HIST = 4'd6;
    localparam logic [3:0] KIND_TCK  = 4'd7;
    localparam logic [3:0] KIND_BAD  = 4'd8;

    // verdict codes
    localparam logic [1:0] STATUS_BUSY = 2'd0;
    localparam logic [1:0] STATUS_OK   = 2'd1;
    localparam logic [1:0] STATUS_ERR  = 2'd2;

    localparam logic [7:0] TS_DIRECT  = 8'h3B;
    localparam logic [7:0] TS_INVERSE = 8'h3F;
    localparam logic [3:0] PROTO_T1   = 4'd1;
    localparam logic [4:0] GROUP_MAX  = 5'd31;
    localparam logic [5:0] COUNT_MAX  = 6'd63;
    localparam logic [5:0] COUNT_MIN  = 6'd2;

    typedef struct packed {
        logic [7:0] atr_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [3:0] byte_kind;
        logic [4:0] group_number;
        logic [7:0] byte_value;
        logic [1:0] status;
        logic       final_res;
        logic       inverse_convention;
        logic       t1_offered;
        logic [3:0] historical_length;
        logic       check_byte_present;
    } result_t;

endpackage

### sv/sca_in_reg.sv
// ----------------------------------------------------------------------------
// sca_in_reg: input word register
// Holds one accepted word until the parse stage takes it.
// ----------------------------------------------------------------------------
module sca_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  sca_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output sca_pkg::item_t out_item
);

    logic           valid_reg;
    logic           valid_next;
    sca_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign out_valid  = valid_reg;
    assign out_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

### sv/sca_parse.sv
// ----------------------------------------------------------------------------
// sca_parse: answer-to-reset parse state and byte classification
// Classifies one byte per take strobe and advances the parse state.
// ----------------------------------------------------------------------------
module sca_parse #(
    parameter int MAX_ATR_BYTES = 33
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             take,
    input  sca_pkg::item_t   item,
    output sca_pkg::result_t result
);

    localparam logic [5:0] MaxBytes = 6'(MAX_ATR_BYTES);

    sca_pkg::phase_t phase_reg, phase_next;
    logic [3:0] pend_reg, pend_next;
    logic [4:0] group_reg, group_next;
    logic [3:0] hist_left_reg, hist_left_next;
    logic [3:0] hist_total_reg, hist_total_next;
    logic [7:0] xor_reg, xor_next;
    logic [5:0] count_reg, count_next;
    logic       t1_reg, t1_next;
    logic       inv_reg, inv_next;
    logic       err_reg, err_next;
    logic       tck_reg, tck_next;

    logic [7:0] b;
    logic [3:0] kind;
    logic [4:0] grp;
    logic [1:0] slot;
    logic [3:0] pend_cleared;
    logic       too_long;
    sca_pkg::phase_t phase_cur;

    // where the parse goes once the interface bytes are done
    function automatic sca_pkg::phase_t after_iface(input logic [3:0] hl, input logic t1);
        sca_pkg::phase_t ph;
        if (hl != 4'd0) begin
            ph = sca_pkg::PH_HIST;
        end else if (t1) begin
            ph = sca_pkg::PH_TCK;
        end else begin
            ph = sca_pkg::PH_DONE;
        end
        return ph;
    endfunction

    assign b = item.atr_byte;

    // lowest pending interface byte among ta, tb, tc, else td
    always_comb begin
        if (pend_reg[0]) begin
            slot = 2'd0;
        end else if (pend_reg[1]) begin
            slot = 2'd1;
        end else if (pend_reg[2]) begin
            slot = 2'd2;
        end else begin
            slot = 2'd3;
        end
        pend_cleared = pend_reg & ~(4'd1 << slot);
    end

    always_comb begin
        phase_next      = phase_reg;
        pend_next       = pend_reg;
        group_next      = group_reg;
        hist_left_next  = hist_left_reg;
        hist_total_next = hist_total_reg;
        xor_next        = xor_reg;
        t1_next         = t1_reg;
        inv_next        = inv_reg;
        err_next        = err_reg;
        tck_next        = tck_reg;
        kind            = sca_pkg::KIND_BAD;
        grp             = 5'd0;

        too_long  = (count_reg >= MaxBytes) && (phase_reg != sca_pkg::PH_ERR);
        phase_cur = phase_reg;
        if (too_long) begin
            err_next  = 1'b1;
            phase_cur = sca_pkg::PH_ERR;
        end else if (phase_reg != sca_pkg::PH_TS && phase_reg != sca_pkg::PH_ERR) begin
            xor_next = xor_reg ^ b;
        end
        phase_next = phase_cur;

        count_next = (count_reg < sca_pkg::COUNT_MAX) ? count_reg + 6'd1 : count_reg;

        unique case (phase_cur)
            sca_pkg::PH_TS: begin
                if (b == sca_pkg::TS_DIRECT || b == sca_pkg::TS_INVERSE) begin
                    kind       = sca_pkg::KIND_TS;
                    inv_next   = (b == sca_pkg::TS_INVERSE);
                    phase_next = sca_pkg::PH_T0;
                end else begin
                    err_next   = 1'b1;
                    phase_next = sca_pkg::PH_ERR;
                end
            end
            sca_pkg::PH_T0: begin
                kind            = sca_pkg::KIND_T0;
                pend_next       = b[7:4];
                hist_left_next  = b[3:0];
                hist_total_next = b[3:0];
                if (b[7:4] != 4'd0) begin
                    group_next = 5'd1;
                    phase_next = sca_pkg::PH_IFACE;
                end else begin
                    phase_next = after_iface(b[3:0], t1_reg);
                end
            end
            sca_pkg::PH_IFACE: begin
                kind      = sca_pkg::KIND_TA + {2'b00, slot};
                grp       = group_reg;
                pend_next = pend_cleared;
                if (slot == 2'd3) begin
                    // td byte: protocol nibble and next group's presence
                    if (b[3:0] == sca_pkg::PROTO_T1) begin
                        t1_next = 1'b1;
                    end
                    if (b[3:0] > sca_pkg::PROTO_T1) begin
                        err_next   = 1'b1;
                        phase_next = sca_pkg::PH_ERR;
                    end else begin
                        pend_next = b[7:4];
                        if (b[7:4] != 4'd0 && group_reg < sca_pkg::GROUP_MAX) begin
                            group_next = group_reg + 5'd1;
                        end
                        if (b[7:4] == 4'd0) begin
                            phase_next = after_iface(hist_left_reg, t1_next);
                        end
                    end
                end else if (pend_cleared == 4'd0) begin
                    phase_next = after_iface(hist_left_reg, t1_reg);
                end
            end
            sca_pkg::PH_HIST: begin
                kind           = sca_pkg::KIND_HIST;
                hist_left_next = hist_left_reg - 4'd1;
                if (hist_left_reg == 4'd1) begin
                    phase_next = t1_reg ? sca_pkg::PH_TCK : sca_pkg::PH_DONE;
                end
            end
            sca_pkg::PH_TCK: begin
                kind     = sca_pkg::KIND_TCK;
                tck_next = 1'b1;
                if (xor_next != 8'd0) begin
                    err_next   = 1'b1;
                    phase_next = sca_pkg::PH_ERR;
                end else begin
                    phase_next = sca_pkg::PH_DONE;
                end
            end
            sca_pkg::PH_DONE: begin
                err_next   = 1'b1;
                phase_next = sca_pkg::PH_ERR;
            end
            default: begin
                kind = sca_pkg::KIND_BAD;
            end
        endcase

        result.byte_kind          = kind;
        result.group_number       = grp;
        result.byte_value         = b;
        result.final_res          = item.last_byte;
        result.inverse_convention = inv_next;
        result.t1_offered         = t1_next;
        result.historical_length  = hist_total_next;
        result.check_byte_present = tck_next;
        if (!item.last_byte) begin
            result.status = sca_pkg::STATUS_BUSY;
        end else if (err_next || count_next < sca_pkg::COUNT_MIN || count_next > MaxBytes
                     || phase_next != sca_pkg::PH_DONE) begin
            result.status = sca_pkg::STATUS_ERR;
        end else begin
            result.status = sca_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && item.last_byte)) begin
            phase_reg      <= sca_pkg::PH_TS;
            pend_reg       <= 4'd0;
            group_reg      <= 5'd0;
            hist_left_reg  <= 4'd0;
            hist_total_reg <= 4'd0;
            xor_reg        <= 8'd0;
            count_reg      <= 6'd0;
            t1_reg         <= 1'b0;
            inv_reg        <= 1'b0;
            err_reg        <= 1'b0;
            tck_reg        <= 1'b0;
        end else if (take) begin
            phase_reg      <= phase_next;
            pend_reg       <= pend_next;
            group_reg      <= group_next;
            hist_left_reg  <= hist_left_next;
            hist_total_reg <= hist_total_next;
            xor_reg        <= xor_next;
            count_reg      <= count_next;
            t1_reg         <= t1_next;
            inv_reg        <= inv_next;
            err_reg        <= err_next;
            tck_reg        <= tck_next;
        end
    end

endmodule

### sv/smart_card_atr_parser.sv
// ----------------------------------------------------------------------------
// smart_card_atr_parser: streaming answer-to-reset parser
// Classifies each answer-to-reset byte and reports the verdict on the last one.
// ----------------------------------------------------------------------------
// One word in gives exactly one word out. A byte goes through an input
// register, is classified combinationally against the parse state, and lands
// in the output register, so the block takes a new byte every cycle while
// m_tready stays high. The result word shows up on the master side once its
// byte has passed the input and output registers, and is held there while
// m_tready is low. The parse state (ts check, t0 decode, the ta/tb/tc/td chain,
// historical byte count and the tck checksum) advances once per byte and clears
// after the byte marked with s_tlast. The verdict in the status field is 0 on
// every byte but the last, then 1 for an accepted answer-to-reset or 2 for a
// parse error (bad ts, bad td protocol, bad checksum, too few or too many
// bytes, missing or excess byte). Flag fields show the state after the byte.
module smart_card_atr_parser #(
    parameter int MAX_ATR_BYTES = 33  // longest legal answer-to-reset, 2 to 63
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words: one received byte each
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] atr_byte
    input  logic        s_tlast,   // last_byte
    // result words: one per input byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] group_number, [12:5] byte_value, [14:13] status,
    // [15] inverse_convention, [16] t1_offered, [20:17] historical_length,
    // [21] check_byte_present, [23:22] zero
    output logic [23:0] m_tdata,
    output logic [3:0]  m_tuser,   // [3:0] byte_kind
    output logic        m_tlast    // final_res
);

    sca_pkg::item_t   s_item;
    sca_pkg::item_t   q_item;
    sca_pkg::result_t res;
    sca_pkg::result_t res_reg;
    logic             q_valid;
    logic             q_ready;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             advance;

    assign s_item.atr_byte  = s_tdata;
    assign s_item.last_byte = s_tlast;

    // input register stage
    sca_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // output register is free or being emptied this cycle
    assign q_ready = !m_valid_reg || m_tready;
    assign advance = q_valid && q_ready;

    // classification and parse state
    sca_parse #(
        .MAX_ATR_BYTES (MAX_ATR_BYTES)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (advance),
        .item    (q_item),
        .result  (res)
    );

    assign m_valid_next = q_ready ? q_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    // pack the result word
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.byte_kind;
    assign m_tlast  = res_reg.final_res;
    assign m_tdata  = {2'b00,
                       res_reg.check_byte_present,
                       res_reg.historical_length,
                       res_reg.t1_offered,
                       res_reg.inverse_convention,
                       res_reg.status,
                       res_reg.byte_value,
                       res_reg.group_number};

endmodule

### tb/atr_checker.sv
// ----------------------------------------------------------------------------
// atr_checker: result predictor and scoreboard for the answer-to-reset parser
// Tracks the parse of each accepted byte, queues the expected result word and
// compares every result word taken from the master side against it.
// ----------------------------------------------------------------------------
module atr_checker #(
    parameter int MAX_ATR_BYTES = 33
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [3:0]  m_tuser,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          pending_words
);

    // parse state as the block should hold it
    sca_pkg::phase_t  parse_phase;
    logic [3:0]       presence_left;
    logic [4:0]       group_idx;
    logic [3:0]       hist_left;
    logic [3:0]       hist_total;
    logic [7:0]       running_xor;
    logic [5:0]       bytes_taken;
    logic             t1_q;
    logic             inverse_q;
    logic             error_q;
    logic             tck_seen;

    sca_pkg::result_t expected_words [$];
    sca_pkg::result_t got;
    sca_pkg::result_t want;
    int               errors = 0;
    int               words_checked = 0;

    task automatic clear_state();
        parse_phase   = sca_pkg::PH_TS;
        presence_left = '0;
        group_idx     = '0;
        hist_left     = '0;
        hist_total    = '0;
        running_xor   = '0;
        bytes_taken   = '0;
        t1_q          = 1'b0;
        inverse_q     = 1'b0;
        error_q       = 1'b0;
        tck_seen      = 1'b0;
    endtask

    task automatic mark_error();
        error_q     = 1'b1;
        parse_phase = sca_pkg::PH_ERR;
    endtask

    // where the parse goes once the interface bytes are used up
    function automatic sca_pkg::phase_t after_iface();
        if (hist_left != 0) return sca_pkg::PH_HIST;
        if (t1_q) return sca_pkg::PH_TCK;
        return sca_pkg::PH_DONE;
    endfunction

    task automatic parse_atr_byte(input logic [7:0] b, input logic last,
                                  output sca_pkg::result_t r);
        int slot;
        r              = '0;
        r.byte_kind    = sca_pkg::KIND_BAD;
        r.group_number = '0;
        r.status       = sca_pkg::STATUS_BUSY;

        if (bytes_taken >= MAX_ATR_BYTES && parse_phase != sca_pkg::PH_ERR) begin
            mark_error();
        end else if (parse_phase != sca_pkg::PH_TS && parse_phase != sca_pkg::PH_ERR) begin
            running_xor ^= b;
        end
        if (bytes_taken < sca_pkg::COUNT_MAX) bytes_taken++;

        case (parse_phase)
            sca_pkg::PH_TS: begin
                if (b == sca_pkg::TS_DIRECT || b == sca_pkg::TS_INVERSE) begin
                    r.byte_kind = sca_pkg::KIND_TS;
                    inverse_q   = (b == sca_pkg::TS_INVERSE);
                    parse_phase = sca_pkg::PH_T0;
                end else begin
                    mark_error();
                end
            end
            sca_pkg::PH_T0: begin
                r.byte_kind   = sca_pkg::KIND_T0;
                presence_left = b[7:4];
                hist_left     = b[3:0];
                hist_total    = b[3:0];
                if (presence_left != 0) begin
                    group_idx   = 5'd1;
                    parse_phase = sca_pkg::PH_IFACE;
                end else begin
                    parse_phase = after_iface();
                end
            end
            sca_pkg::PH_IFACE: begin
                // lowest pending of ta, tb, tc, else td
                slot = 0;
                while (slot < 3 && !presence_left[slot]) slot++;
                r.byte_kind          = sca_pkg::KIND_TA + 4'(slot);
                r.group_number       = group_idx;
                presence_left[slot]  = 1'b0;
                if (r.byte_kind == sca_pkg::KIND_TD) begin
                    if (b[3:0] == sca_pkg::PROTO_T1) t1_q = 1'b1;
                    if (b[3:0] > sca_pkg::PROTO_T1) begin
                        mark_error();
                    end else begin
                        presence_left = b[7:4];
                        if (presence_left != 0 && group_idx < sca_pkg::GROUP_MAX)
                            group_idx++;
                        if (presence_left == 0) parse_phase = after_iface();
                    end
                end else if (presence_left == 0) begin
                    parse_phase = after_iface();
                end
            end
            sca_pkg::PH_HIST: begin
                r.byte_kind = sca_pkg::KIND_HIST;
                hist_left--;
                if (hist_left == 0)
                    parse_phase = t1_q ? sca_pkg::PH_TCK : sca_pkg::PH_DONE;
            end
            sca_pkg::PH_TCK: begin
                r.byte_kind = sca_pkg::KIND_TCK;
                tck_seen    = 1'b1;
                if (running_xor != 0) mark_error();
                else parse_phase = sca_pkg::PH_DONE;
            end
            sca_pkg::PH_DONE: begin
                mark_error();
            end
            default: ;
        endcase

        if (last) begin
            if (error_q || bytes_taken < sca_pkg::COUNT_MIN || bytes_taken > MAX_ATR_BYTES ||
                parse_phase != sca_pkg::PH_DONE)
                r.status = sca_pkg::STATUS_ERR;
            else
                r.status = sca_pkg::STATUS_OK;
        end

        r.byte_value         = b;
        r.final_res          = last;
        r.inverse_convention = inverse_q;
        r.t1_offered         = t1_q;
        r.historical_length  = hist_total;
        r.check_byte_present = tck_seen;

        if (last) clear_state();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            expected_words.delete();
        end else begin
            // compare before queueing, so a stray word never meets a fresh entry
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[4:0], m_tdata[12:5], m_tdata[14:13], m_tlast,
                       m_tdata[15], m_tdata[16], m_tdata[20:17], m_tdata[21]};
                if (expected_words.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result word %0d arrived with nothing expected: %h",
                                 words_checked, got);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"result word %0d (exp/act): kind %0d/%0d grp %0d/%0d ",
                                      "byte %h/%h status %0d/%0d last %b/%b inv %b/%b ",
                                      "t1 %b/%b hist %0d/%0d tck %b/%b"},
                                     words_checked,
                                     want.byte_kind, got.byte_kind,
                                     want.group_number, got.group_number,
                                     want.byte_value, got.byte_value,
                                     want.status, got.status,
                                     want.final_res, got.final_res,
                                     want.inverse_convention, got.inverse_convention,
                                     want.t1_offered, got.t1_offered,
                                     want.historical_length, got.historical_length,
                                     want.check_byte_present, got.check_byte_present);
                    end
                end
                words_checked++;
            end
            if (s_tvalid && s_tready) begin
                parse_atr_byte(s_tdata, s_tlast, want);
                expected_words = {expected_words, want};
            end
        end
        mismatch_count <= errors;
        pending_words  <= expected_words.size();
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream testbench of the answer-to-reset parser
// Feeds directed and random answer-to-reset byte sequences with random idle
// bursts on both sides; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_BYTES   = 33;
    localparam int WORD_TARGET = 950;   // random stimulus stops past this
    localparam int QUIET_FROM  = 860;   // no idling from here to the end
    localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_WAIT  = 16;    // extra wait after the drain, keeps margin

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    int          mismatch_count;
    int          pending_words;
    int          words_sent   = 0;
    int          stall_cycles = 0;
    logic        quiet        = 1'b0;

    // bytes of the answer-to-reset about to be sent
    logic [7:0]  atr_buf [$];

    smart_card_atr_parser #(
        .MAX_ATR_BYTES (MAX_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    atr_checker #(
        .MAX_ATR_BYTES (MAX_BYTES)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result side backpressure: random low bursts, none in the quiet tail
    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (aresetn && !quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: nothing moving for too long means the block hung
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one input word; sometimes preceded by an idle burst on the valid line
    task automatic send_word(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (words_sent >= QUIET_FROM) quiet = 1'b1;
    endtask

    // send the buffer, flagging its final byte with tlast
    task automatic send_atr();
        for (int i = 0; i < atr_buf.size(); i++)
            send_word(atr_buf[i], i == atr_buf.size() - 1);
    endtask

    // append one byte to the buffer
    task automatic add_byte(input logic [7:0] v);
        atr_buf = {atr_buf, v};
    endtask

    // random answer-to-reset: mostly well formed with random content,
    // the rest with one fault, or plain noise
    task automatic build_atr();
        int          groups;
        int          hist_n;
        int          pick;
        logic [3:0]  pres;
        logic [3:0]  next_pres;
        logic [3:0]  proto;
        logic [7:0]  chk;
        logic        t1;
        atr_buf.delete();
        t1     = 1'b0;
        groups = $urandom_range(0, 4);
        // historical count mostly short, sometimes up to the full nibble
        hist_n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
        pres   = (groups == 0) ? 4'h0 : {groups > 1, 3'($urandom_range(0, 7))};
        add_byte($urandom_range(0, 1) ? sca_pkg::TS_INVERSE : sca_pkg::TS_DIRECT);
        add_byte({pres, 4'(hist_n)});
        for (int g = 1; g <= groups && pres != 0; g++) begin
            for (int i = 0; i < 3; i++)
                if (pres[i]) add_byte(8'($urandom));
            if (pres[3]) begin
                next_pres = {g + 1 < groups, 3'($urandom_range(0, 7))};
                // now and then a protocol nibble other than t=0 or t=1
                proto = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(2, 15))
                                                     : 4'($urandom_range(0, 1));
                if (proto == sca_pkg::PROTO_T1) t1 = 1'b1;
                add_byte({next_pres, proto});
                pres = next_pres;
            end else begin
                pres = 4'h0;
            end
        end
        repeat (hist_n) add_byte(8'($urandom));
        // tck makes the xor from t0 on come out zero
        if (t1) begin
            chk = 8'h00;
            for (int i = 1; i < atr_buf.size(); i++) chk ^= atr_buf[i];
            add_byte(chk);
        end

        pick = $urandom_range(0, 19);
        case (pick)
            0: atr_buf[0] = 8'($urandom);                              // bad ts
            1: atr_buf.delete($urandom_range(1, atr_buf.size() - 1));  // missing byte
            2: add_byte(8'($urandom));                                  // excess byte
            3: atr_buf[atr_buf.size() - 1] ^= 8'($urandom_range(1, 255));
            4: atr_buf[$urandom_range(1, atr_buf.size() - 1)] = 8'($urandom);
            5: begin
                atr_buf.delete();
                repeat ($urandom_range(1, 40)) add_byte(8'($urandom));
            end
            6: begin
                // long td-only chain around the length limit
                atr_buf.delete();
                add_byte(sca_pkg::TS_DIRECT);
                add_byte(8'h80);
                repeat ($urandom_range(27, 33)) add_byte(8'h80);
                add_byte(8'h00);
            end
            7: begin
                // runaway stream, drives the byte counter into saturation
                if ($urandom_range(0, 2) == 0) begin
                    atr_buf.delete();
                    add_byte(sca_pkg::TS_DIRECT);
                    repeat ($urandom_range(64, 80)) add_byte(8'($urandom));
                end
            end
            default: ;
        endcase
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn  <= 1'b1;

        // shortest legal answer-to-reset
        atr_buf = '{sca_pkg::TS_DIRECT, 8'h00};
        send_atr();
        // too short: ts alone
        atr_buf = '{sca_pkg::TS_DIRECT};
        send_atr();
        // bad ts
        atr_buf = '{8'h00};
        send_atr();
        // full first group with t=1, two historical bytes and a good tck
        atr_buf = '{sca_pkg::TS_INVERSE, 8'hF2, 8'hFF, 8'h00, 8'h55, 8'h01, 8'hAA,
                    8'h80, 8'h73};
        send_atr();
        // td offering an unknown protocol
        atr_buf = '{sca_pkg::TS_DIRECT, 8'h80, 8'h0F};
        send_atr();
        // excess byte after a complete structure
        atr_buf = '{sca_pkg::TS_DIRECT, 8'h00, 8'h55};
        send_atr();
        // t=1 offered but the check byte leaves a nonzero xor
        atr_buf = '{sca_pkg::TS_DIRECT, 8'h80, 8'h01, 8'h00};
        send_atr();

        while (words_sent < WORD_TARGET) begin
            build_atr();
            send_atr();
        end
        s_tvalid <= 1'b0;

        // drain, then keep waiting so that stray words can still show
        while (pending_words != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatch_count == 0 && pending_words == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
